FILE: src/bse_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes for the binary square erosion core
package bse_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_RADIUS = 3;

    localparam int RADIUS_W   = 2;
    localparam int THRESH_W   = 8;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 8;
    localparam int OUT_DATA_W = 8;

    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [RADIUS_W-1:0] RST_RADIUS    = 2'd1;
    localparam logic [THRESH_W-1:0] RST_THRESHOLD = 8'd224;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH     = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT    = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS    = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic active;
    } t_cell_ctl;

endpackage

FILE: src/bse_cell.sv
`timescale 1ns / 1ps
// One column of the erosion window: holds a column word and folds it into the AND chain
module bse_cell
    import bse_pkg::*;
#(
    parameter int WORD_W = 2 * DEF_MAX_RADIUS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [WORD_W-1:0] i_mask,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_carry,
    output logic [WORD_W-1:0] o_word,
    output logic              o_carry
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    assign n_word = i_ctl.shift ? i_word : r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word  = r_word;
    assign o_carry = i_carry & (~i_ctl.active | ((n_word & i_mask) == i_mask));

endmodule

FILE: src/bse_row_store.sv
`timescale 1ns / 1ps
// Row history memory: one write and one registered read per cycle, write-through on a clash
module bse_row_store
    import bse_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int DATA_W = 2 * DEF_MAX_RADIUS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_fwd_data;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;

endmodule

FILE: src/binary_square_erosion_core.sv
`timescale 1ns / 1ps
// Streaming binary erosion with a square window over thresholded gray pixels
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser kind, tdata gray
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata eroded_pixel, tlast last
//  cfg      | in        | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One request per clock while s_axis_tready is high; results enter the output or skid register.
// Results trail requests by radius*width+radius items, set by the row store and the cell chain.
// s_axis_tready drops only while both output register and skid register hold results.
// Reset clears counters and cells, presets the configuration; the row store needs no clearing.
module binary_square_erosion_core
    import bse_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] gray
    input  logic                  s_axis_tuser,   // [0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] eroded_pixel, [7:1] zero
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NCELL   = 2 * MAX_RADIUS + 1;
    localparam int STORE_W = 2 * MAX_RADIUS;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WC_W    = $clog2(MAX_WIDTH + 1);
    localparam int RC_W    = $clog2(MAX_RADIUS + 1);
    localparam int EXT_W   = ((WC_W > ROW_W) ? WC_W : ROW_W) + 1;

    // configuration
    logic [RADIUS_W-1:0] r_radius, n_radius;
    logic [THRESH_W-1:0] r_thresh, n_thresh;
    logic [WIDTH_W-1:0]  r_width,  n_width;
    logic [HEIGHT_W-1:0] r_height, n_height;

    // frame position
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    // output register and skid
    logic r_out_valid,  n_out_valid;
    logic r_out_pix,    n_out_pix;
    logic r_out_last,   n_out_last;
    logic r_skid_valid, n_skid_valid;
    logic r_skid_pix,   n_skid_pix;
    logic r_skid_last,  n_skid_last;

    logic [WC_W-1:0]     w_c, nw_c;
    logic [HEIGHT_W-1:0] h_c;
    logic [RC_W-1:0]     rad;
    logic [ROW_W-1:0]    em_row;
    logic [EXT_W-1:0]    em_col;

    logic               acc, skip, step;
    logic               in_wrap, out_wrap, in_end, out_end;
    logic [COL_W-1:0]   c_in, c_out;
    logic [ROW_W-1:0]   row_in, row_out;
    logic               bit_in, emit, edge_ok, last, res;
    logic [STORE_W-1:0] rd_data;
    logic [NCELL-1:0]   word;
    logic [NCELL-1:0]   mask;
    logic [COL_W-1:0]   rd_addr;

    logic [NCELL-1:0][NCELL-1:0] cell_word;
    logic [NCELL:0]              carry;

    function automatic logic [WC_W-1:0] clamp_w(input logic [WIDTH_W-1:0] v);
        logic [WC_W-1:0] cw;
        if (v == '0) begin
            cw = WC_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            cw = WC_W'(MAX_WIDTH);
        end else begin
            cw = WC_W'(v);
        end
        return cw;
    endfunction

    always_comb begin
        n_radius = r_radius;
        n_thresh = r_thresh;
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS:    n_radius = i_cfg_data[RADIUS_W-1:0];
                CFG_THRESHOLD: n_thresh = i_cfg_data[THRESH_W-1:0];
                CFG_WIDTH:     n_width  = i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT:    n_height = i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        w_c  = clamp_w(r_width);
        nw_c = clamp_w(n_width);
        if (r_height == '0) begin
            h_c = HEIGHT_W'(1);
        end else if (32'(r_height) > HEIGHT_LIMIT) begin
            h_c = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            h_c = r_height;
        end
        if (r_radius == '0) begin
            rad = RC_W'(1);
        end else if (32'(r_radius) > MAX_RADIUS) begin
            rad = RC_W'(MAX_RADIUS);
        end else begin
            rad = RC_W'(r_radius);
        end
    end

    // first emitting input position: row and column of index radius*width+radius
    always_comb begin
        em_row = ROW_W'(rad);
        em_col = EXT_W'(rad);
        for (int i = 0; i < MAX_RADIUS; i++) begin
            if (em_col >= EXT_W'(w_c)) begin
                em_col = em_col - EXT_W'(w_c);
                em_row = em_row + ROW_W'(1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NCELL; k++) begin
            mask[k] = (k <= 2 * int'(rad));
        end
    end

    assign s_axis_tready = ~r_skid_valid;
    assign acc  = s_axis_tvalid & s_axis_tready;
    assign skip = s_axis_tuser && (r_in_row == '0) && (r_in_col == '0);
    assign step = acc & ~skip;

    always_comb begin
        in_wrap  = EXT_W'(r_in_col) >= EXT_W'(w_c);
        c_in     = in_wrap ? '0 : r_in_col;
        row_in   = in_wrap ? r_in_row + ROW_W'(1) : r_in_row;
        out_wrap = EXT_W'(r_out_col) >= EXT_W'(w_c);
        c_out    = out_wrap ? '0 : r_out_col;
        row_out  = out_wrap ? r_out_row + ROW_W'(1) : r_out_row;

        bit_in = ~s_axis_tuser && (EXT_W'(row_in) < EXT_W'(h_c))
                 && (s_axis_tdata <= r_thresh);
        word   = {rd_data, bit_in};
        emit   = (row_in > em_row) || ((row_in == em_row) && (EXT_W'(c_in) >= em_col));

        in_end  = (EXT_W'(c_in) + EXT_W'(1)) >= EXT_W'(w_c);
        out_end = (EXT_W'(c_out) + EXT_W'(1)) >= EXT_W'(w_c);

        edge_ok = (EXT_W'(row_out) >= EXT_W'(rad))
                  && ((EXT_W'(row_out) + EXT_W'(rad)) < EXT_W'(h_c))
                  && (EXT_W'(c_out) >= EXT_W'(rad))
                  && ((EXT_W'(c_out) + EXT_W'(rad)) < EXT_W'(w_c));
        last    = (EXT_W'(row_out) >= EXT_W'(h_c))
                  || ((EXT_W'(row_out) == EXT_W'(h_c) - EXT_W'(1))
                      && (EXT_W'(c_out) >= EXT_W'(w_c) - EXT_W'(1)));
        res     = edge_ok & carry[NCELL];
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (step) begin
            n_in_col  = in_end ? '0 : c_in + COL_W'(1);
            n_in_row  = in_end ? row_in + ROW_W'(1) : row_in;
            n_out_col = c_out;
            n_out_row = row_out;
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else begin
                    n_out_col = out_end ? '0 : c_out + COL_W'(1);
                    n_out_row = out_end ? row_out + ROW_W'(1) : row_out;
                end
            end
        end
    end

    // column of the next step, read in the cycle before that step
    assign rd_addr = (EXT_W'(n_in_col) >= EXT_W'(nw_c)) ? '0 : n_in_col;

    bse_row_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (STORE_W)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (step),
        .i_waddr (c_in),
        .i_wdata (word[STORE_W-1:0]),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign carry[0] = 1'b1;

    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        t_cell_ctl        ctl;
        logic [NCELL-1:0] w_in;

        assign ctl.shift  = step;
        assign ctl.active = mask[gi];

        if (gi == 0) begin : g_head
            assign w_in = word;
        end else begin : g_body
            assign w_in = cell_word[gi-1];
        end

        bse_cell #(
            .WORD_W (NCELL)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_mask  (mask),
            .i_word  (w_in),
            .i_carry (carry[gi]),
            .o_word  (cell_word[gi]),
            .o_carry (carry[gi+1])
        );
    end

    // output register with skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_pix    = r_out_pix;
        n_out_last   = r_out_last;
        n_skid_valid = r_skid_valid;
        n_skid_pix   = r_skid_pix;
        n_skid_last  = r_skid_last;
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_pix    = r_skid_pix;
                n_out_last   = r_skid_last;
                n_skid_valid = step & emit;
                n_skid_pix   = res;
                n_skid_last  = last;
            end else begin
                n_out_valid = step & emit;
                n_out_pix   = res;
                n_out_last  = last;
            end
        end else if (step && emit) begin
            n_skid_valid = 1'b1;
            n_skid_pix   = res;
            n_skid_last  = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RST_RADIUS;
            r_thresh     <= RST_THRESHOLD;
            r_width      <= RST_WIDTH;
            r_height     <= RST_HEIGHT;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_radius     <= n_radius;
            r_thresh     <= n_thresh;
            r_width      <= n_width;
            r_height     <= n_height;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pix   <= n_out_pix;
        r_out_last  <= n_out_last;
        r_skid_pix  <= n_skid_pix;
        r_skid_last <= n_skid_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_out_pix};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !$past(m_axis_tready)))
        else $error("input stalled without a held result");

    a_last_is_border : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[0])
        else $error("final pixel of a frame eroded to foreground");

    a_last_clears_position : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit && last) |=> (r_in_col == '0 && r_in_row == '0 && r_out_row == '0))
        else $error("frame position not cleared after final pixel");
`endif

endmodule

FILE: dv/binary_square_erosion_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the binary square erosion core: stream stimulus and pixel checker
module binary_square_erosion_core_tb;
    import bse_pkg::*;

    localparam int WIN_BITS       = 2 * DEF_MAX_RADIUS + 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int SMALL_ITEMS    = 1000;

    typedef struct packed {
        logic pixel;
        logic last;
    } t_eroded;

    // Tracks the erosion state per request and checks each output pixel in order
    class erosion_checker;
        bit [RADIUS_W-1:0]         radius;
        bit [THRESH_W-1:0]         threshold;
        bit [WIDTH_W-1:0]          width;
        bit [HEIGHT_W-1:0]         height;
        bit [WIN_BITS-2:0]         col_history [DEF_MAX_WIDTH];
        bit [WIN_BITS-1:0]         window_cols [WIN_BITS];
        int unsigned               in_col;
        int unsigned               out_col;
        bit [ROW_W-1:0]            in_row;
        bit [ROW_W-1:0]            out_row;
        t_eroded                   pending_pixels [$];
        int                        failures;

        function new();
            radius    = RST_RADIUS;
            threshold = RST_THRESHOLD;
            width     = RST_WIDTH;
            height    = RST_HEIGHT;
        endfunction

        function void write_reg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RADIUS:    radius    = value[RADIUS_W-1:0];
                CFG_THRESHOLD: threshold = value[THRESH_W-1:0];
                CFG_WIDTH:     width     = value[WIDTH_W-1:0];
                CFG_HEIGHT:    height    = value[HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(bit kind, bit [PIX_W-1:0] gray);
            int unsigned w, h, r, mask, j;
            bit fg, hit;
            bit [WIN_BITS-1:0] word;
            t_eroded res;
            w = (width == 0) ? 1 : (width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width;
            h = (height == 0) ? 1 : (height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height;
            r = (radius == 0) ? 1 : (radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius;
            // flush with no frame open is dropped
            if (kind && in_row == 0 && in_col == 0)
                return;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            fg = !kind && (in_row < h) && (gray <= threshold);
            word = {col_history[in_col], fg};
            col_history[in_col] = word[WIN_BITS-2:0];
            for (j = WIN_BITS - 1; j > 0; j--)
                window_cols[j] = window_cols[j-1];
            window_cols[0] = word;
            hit = (in_row * w + in_col) >= (r * w + r);
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (!hit)
                return;
            res.pixel = 1'b0;
            if (out_row >= r && out_row + r < h && out_col >= r && out_col + r < w) begin
                mask = (1 << (2 * r + 1)) - 1;
                res.pixel = 1'b1;
                for (j = 0; j <= 2 * r; j++)
                    if ((window_cols[j] & mask) != mask)
                        res.pixel = 1'b0;
            end
            res.last = (out_row >= h) || (out_row == h - 1 && out_col >= w - 1);
            pending_pixels.push_back(res);
            if (res.last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_pixel(logic [OUT_DATA_W-1:0] data, logic last);
            t_eroded want;
            if (pending_pixels.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result tdata %h tlast %b", $time, data, last);
                return;
            end
            want = pending_pixels.pop_front();
            if (data !== {{(OUT_DATA_W-1){1'b0}}, want.pixel} || last !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: expected pixel %b last %b, got tdata %h tlast %b",
                             $time, want.pixel, want.last, data, last);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;   // [7:0] gray
    logic                  s_axis_tuser;   // [0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] eroded_pixel, [7:1] zero
    logic                  m_axis_tlast;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    erosion_checker sb = new();
    bit             src_gaps;
    bit             sink_gaps;
    int             hold_requests;

    binary_square_erosion_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    // receiver: random back-pressure, plus long hold-offs on request from stimulus
    initial begin : sink
        int holds_done;
        holds_done = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                holds_done++;
            end else begin
                m_axis_tready <= !(sink_gaps && $urandom_range(99, 0) < 28);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned eff(int unsigned value, int unsigned top);
        return (value == 0) ? 1 : (value > top) ? top : value;
    endfunction

    task automatic send_item(bit kind, bit [PIX_W-1:0] gray);
        while (src_gaps && $urandom_range(99, 0) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= gray;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // drain all expected pixels, then give the pipeline time to empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic configure(int unsigned rad, int unsigned thr, int unsigned wid,
                             int unsigned hgt);
        write_reg(CFG_RADIUS, 13'(rad));
        write_reg(CFG_THRESHOLD, 13'(thr));
        write_reg(CFG_WIDTH, 13'(wid));
        write_reg(CFG_HEIGHT, 13'(hgt));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned phase, small_items, nframes, f, i;
        int unsigned rad_reg, thr, wid_reg, hgt_reg, w, h, r, fg_pct;
        bit          kind;
        bit [7:0]    gray;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_RADIUS;
        i_cfg_data    <= '0;
        hold_requests <= 0;
        sink_gaps     <= 1'b1;
        src_gaps      = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flush with no frame open: dropped
        send_item(1'b1, 8'h5A);
        settle();
        // 4x3, radius 1: threshold edge, flush inside the image, pixels past the last row
        configure(1, 128, 4, 3);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd128);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd129);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd0);
        send_item(1'b1, 8'd0);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'd0);
        send_item(1'b1, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b1, 8'h33);
        send_item(1'b1, 8'hC3);
        settle();
        // zero radius, width and height all act as 1
        configure(0, 0, 0, 0);
        send_item(1'b0, 8'd0);
        send_item(1'b1, 8'd0);
        send_item(1'b0, 8'hFF);

        phase = 0;
        small_items = 0;
        while (small_items < SMALL_ITEMS) begin
            settle();
            src_gaps = (phase != 2);
            sink_gaps <= (phase != 2);
            rad_reg = $urandom_range(3, 0);
            thr = ($urandom_range(7, 0) == 0) ? 0 :
                  ($urandom_range(7, 0) == 0) ? 255 : $urandom_range(255, 0);
            wid_reg = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(12, 1);
            hgt_reg = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(12, 1);
            nframes = $urandom_range(3, 1);
            case (phase)
                0, 8: begin
                    rad_reg = 1;
                    wid_reg = 10;
                    hgt_reg = 10;
                    hold_requests <= hold_requests + 1;
                end
                1: begin
                    rad_reg = 3;
                    wid_reg = 9;
                    hgt_reg = 9;
                    thr     = 255;
                end
                2: begin
                    rad_reg = 2;
                    wid_reg = 12;
                    hgt_reg = 12;
                    nframes = 1;
                end
                default: ;
            endcase
            configure(rad_reg, thr, wid_reg, hgt_reg);
            w = eff(wid_reg, DEF_MAX_WIDTH);
            h = eff(hgt_reg, HEIGHT_LIMIT);
            r = eff(rad_reg, DEF_MAX_RADIUS);
            for (f = 0; f < nframes; f++) begin
                case ($urandom_range(3, 0))
                    0:       fg_pct = 50;
                    1:       fg_pct = 85;
                    2:       fg_pct = 97;
                    default: fg_pct = 100;
                endcase
                for (i = 0; i < w * h; i++) begin
                    // occasional flush inside the image, never as the opening item
                    kind = (i != 0) && ($urandom_range(99, 0) < 3);
                    if ($urandom_range(99, 0) < fg_pct)
                        gray = 8'($urandom_range(thr, 0));
                    else
                        gray = (thr == 255) ? 8'd255 : 8'($urandom_range(255, thr + 1));
                    send_item(kind, gray);
                end
                for (i = 0; i < r * w + r; i++)
                    send_item($urandom_range(3, 0) != 0, 8'($urandom));
                if ($urandom_range(3, 0) == 0)
                    send_item(1'b1, 8'($urandom));
                small_items += w * h + r * w + r;
            end
            phase++;
        end

        settle();
        if (sb.failures == 0 && sb.pending_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
src/bse_pkg.sv
src/bse_cell.sv
src/bse_row_store.sv
src/binary_square_erosion_core.sv
dv/binary_square_erosion_core_tb.sv
